// ----- src/subaperture_threshold_centroid_macros.svh -----
// ----------------------------------------------------------------------------
// subaperture centroid assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef SUBAPERTURE_THRESHOLD_CENTROID_MACROS_SVH
`define SUBAPERTURE_THRESHOLD_CENTROID_MACROS_SVH

// same-cycle implication
`define STC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stc check failed");

// next-cycle implication
`define STC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stc check failed");

`endif

// ----- src/stc_pkg.sv -----
// ----------------------------------------------------------------------------
// stc_pkg
// shared types, widths and codes of the subaperture centroid block
// ----------------------------------------------------------------------------
package stc_pkg;

  localparam int MAX_IMAGE_DEF     = 512;
  localparam int MAX_SUB_DEF       = 32;
  localparam int MAX_ACROSS_DEF    = 64;
  localparam int MAX_APERTURES_DEF = 1024;

  localparam int THRESH_LIMIT = 8000;

  localparam int TW    = 13;
  localparam int DIMW  = 10;
  localparam int SUBW  = 6;
  localparam int PIXW  = 16;
  localparam int IDXW  = 10;
  localparam int CTRW  = 13;
  localparam int WSW   = 25;
  localparam int MOMW  = 30;
  localparam int QFRAC = 8;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 13;

  localparam logic [CFG_AW-1:0] REG_THRESHOLD    = 3'd0;
  localparam logic [CFG_AW-1:0] REG_IMAGE_WIDTH  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_IMAGE_HEIGHT = 3'd2;
  localparam logic [CFG_AW-1:0] REG_SUB_WIDTH    = 3'd3;
  localparam logic [CFG_AW-1:0] REG_SUB_HEIGHT   = 3'd4;

  localparam logic [TW-1:0]   THRESHOLD_RST    = 13'd1;
  localparam logic [DIMW-1:0] IMAGE_WIDTH_RST  = 10'd240;
  localparam logic [DIMW-1:0] IMAGE_HEIGHT_RST = 10'd240;
  localparam logic [SUBW-1:0] SUB_WIDTH_RST    = 6'd10;
  localparam logic [SUBW-1:0] SUB_HEIGHT_RST   = 6'd10;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_MASK  = 1'b1;

  localparam int QDEPTH = 2;

  typedef enum logic [1:0] {F_CLEAR, F_IDLE, F_READ, F_UPDATE} front_state_t;
  typedef enum logic [1:0] {B_IDLE, B_DIV, B_DONE} back_state_t;

  typedef struct packed {
    logic [IDXW-1:0] idx;
    logic [WSW-1:0]  ws;
    logic [MOMW-1:0] rm;
    logic [MOMW-1:0] cm;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- src/stc_front.sv -----
// ----------------------------------------------------------------------------
// stc_front
// raster tracking, mask store, per-column accumulators and job issue
// ----------------------------------------------------------------------------
module stc_front #(
  parameter int MAX_IMAGE     = stc_pkg::MAX_IMAGE_DEF,
  parameter int MAX_SUB       = stc_pkg::MAX_SUB_DEF,
  parameter int MAX_ACROSS    = stc_pkg::MAX_ACROSS_DEF,
  parameter int MAX_APERTURES = stc_pkg::MAX_APERTURES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [stc_pkg::CFG_AW-1:0]  cfg_index,
  input  logic [stc_pkg::CFG_DW-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        operation,
  input  logic signed [stc_pkg::PIXW-1:0] pixel,
  input  logic                        frame_start,
  input  logic [stc_pkg::IDXW-1:0]    mask_index,
  input  logic                        mask_bit,
  output logic                        job_push,
  output stc_pkg::job_t               job,
  input  stc_pkg::q_stat_t            q_stat
);
  import stc_pkg::*;

  localparam int IW   = $clog2(MAX_IMAGE + 1);
  localparam int PW   = $clog2(MAX_IMAGE);
  localparam int SW   = $clog2(MAX_SUB + 1);
  localparam int LW   = $clog2(MAX_SUB);
  localparam int AW   = $clog2(MAX_ACROSS);
  localparam int CW   = $clog2(MAX_ACROSS + 1);
  localparam int MW   = $clog2(MAX_APERTURES);
  localparam int NW   = PW + CW;
  localparam int DW   = (IW > DIMW) ? IW : DIMW;
  localparam int SXW  = (SW > SUBW) ? SW : SUBW;
  localparam int GCW  = $clog2(IW + 1);

  front_state_t state, state_next;

  logic [TW-1:0]   threshold;
  logic [DIMW-1:0] image_width, image_height;
  logic [SUBW-1:0] sub_width, sub_height;

  logic [IW-1:0] w_eff, h_eff;
  logic [SW-1:0] sw_eff, sh_eff;
  logic          grid_on;

  logic [PW-1:0] raster_col, raster_row, gc, gr;
  logic [LW-1:0] lc, lr;
  logic [NW-1:0] row_base;
  logic [IDXW-1:0] enabled_count;
  logic [CW-1:0] across;
  logic [IW-1:0] down;

  logic           geo_busy, geo_load;
  logic [2:0]     geo_step;
  logic [GCW-1:0] geo_cnt;
  logic [IW-1:0]  geo_dvd, geo_quo, sel_dvd;
  logic [SW-1:0]  geo_rem, sel_div;
  logic [SW:0]    geo_cand;

  logic [MW-1:0] clr_cnt;

  logic [WSW-1:0]  ws_mem [MAX_ACROSS];
  logic [MOMW-1:0] rm_mem [MAX_ACROSS];
  logic [MOMW-1:0] cm_mem [MAX_ACROSS];
  logic            mask_mem [MAX_APERTURES];
  logic [MAX_ACROSS-1:0] acc_vld;

  logic [WSW-1:0]  rd_ws;
  logic [MOMW-1:0] rd_rm, rd_cm;
  logic            rd_vld, rd_mask;
  logic            in_grid_q, last_q, num_ok_q;
  logic signed [PIXW-1:0] px_q;

  logic            accept, mask_wr, in_grid, last, num_ok, pass, emit, hold, acc_we;
  logic            col_wrap, row_wrap;
  logic [NW-1:0]   num;
  logic [AW-1:0]   acc_addr;
  logic [WSW-1:0]  ws_base, ws_new, v;
  logic [MOMW-1:0] rm_base, cm_base, rm_new, cm_new;

  // effective geometry
  always_comb begin
    if (image_width == '0) begin
      w_eff = IW'(1);
    end else if (DW'(image_width) > DW'(MAX_IMAGE)) begin
      w_eff = IW'(MAX_IMAGE);
    end else begin
      w_eff = IW'(image_width);
    end
    if (image_height == '0) begin
      h_eff = IW'(1);
    end else if (DW'(image_height) > DW'(MAX_IMAGE)) begin
      h_eff = IW'(MAX_IMAGE);
    end else begin
      h_eff = IW'(image_height);
    end
    sw_eff  = (SXW'(sub_width) > SXW'(MAX_SUB)) ? SW'(MAX_SUB) : SW'(sub_width);
    sh_eff  = (SXW'(sub_height) > SXW'(MAX_SUB)) ? SW'(MAX_SUB) : SW'(sub_height);
    grid_on = (sub_width != '0) && (sub_height != '0);
  end

  always_comb begin
    case (geo_step)
      3'd0:    begin sel_dvd = w_eff;           sel_div = sw_eff; end
      3'd1:    begin sel_dvd = h_eff;           sel_div = sh_eff; end
      3'd2:    begin sel_dvd = IW'(raster_col); sel_div = sw_eff; end
      default: begin sel_dvd = IW'(raster_row); sel_div = sh_eff; end
    endcase
    geo_cand = {geo_rem, geo_dvd[IW-1]};
  end

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != F_IDLE) || geo_busy;
  assign mask_wr  = accept && (operation == OP_MASK) && (int'(mask_index) < MAX_APERTURES);

  assign num      = row_base + NW'(gc);
  assign acc_addr = AW'(gc);
  assign in_grid  = grid_on && (NW'(gc) < NW'(across)) && (IW'(gr) < down);
  assign last     = (lc == LW'(sw_eff - 1'b1)) && (lr == LW'(sh_eff - 1'b1));
  assign num_ok   = int'(num) < MAX_APERTURES;

  always_comb begin
    pass    = $signed({px_q[PIXW-1], px_q}) > $signed({4'b0000, threshold});
    v       = WSW'(px_q[PIXW-2:0]);
    ws_base = rd_vld ? rd_ws : '0;
    rm_base = rd_vld ? rd_rm : '0;
    cm_base = rd_vld ? rd_cm : '0;
    ws_new  = ws_base + (pass ? v : '0);
    rm_new  = rm_base + (pass ? MOMW'(v) * MOMW'(lr) : '0);
    cm_new  = cm_base + (pass ? MOMW'(v) * MOMW'(lc) : '0);
    emit    = in_grid_q && last_q && num_ok_q && rd_mask;
    hold    = emit && q_stat.full;
    acc_we  = (state == F_UPDATE) && !hold && in_grid_q && !last_q;
    job_push = (state == F_UPDATE) && emit && !q_stat.full;
    job     = '{idx: enabled_count, ws: ws_new, rm: rm_new, cm: cm_new};
    col_wrap = (IW'(raster_col) + IW'(1)) >= w_eff;
    row_wrap = (IW'(raster_row) + IW'(1)) >= h_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      F_CLEAR:  if (clr_cnt == MW'(MAX_APERTURES - 1)) state_next = F_IDLE;
      F_IDLE:   if (accept && (operation == OP_PIXEL)) state_next = F_READ;
      F_READ:   state_next = F_UPDATE;
      F_UPDATE: if (!hold) state_next = F_IDLE;
      default:  state_next = F_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= THRESHOLD_RST;
      image_width  <= IMAGE_WIDTH_RST;
      image_height <= IMAGE_HEIGHT_RST;
      sub_width    <= SUB_WIDTH_RST;
      sub_height   <= SUB_HEIGHT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_THRESHOLD: begin
          if ((cfg_data != '0) && (cfg_data < TW'(THRESH_LIMIT))) threshold <= cfg_data;
        end
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[DIMW-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[DIMW-1:0];
        REG_SUB_WIDTH:    sub_width    <= cfg_data[SUBW-1:0];
        REG_SUB_HEIGHT:   sub_height   <= cfg_data[SUBW-1:0];
        default: ;
      endcase
    end
  end

  // control and raster state
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt       <= '0;
      geo_busy      <= 1'b1;
      geo_load      <= 1'b1;
      geo_step      <= '0;
      geo_cnt       <= '0;
      raster_col    <= '0;
      raster_row    <= '0;
      lc            <= '0;
      lr            <= '0;
      gc            <= '0;
      gr            <= '0;
      row_base      <= '0;
      enabled_count <= '0;
      across        <= '0;
      down          <= '0;
      acc_vld       <= '0;
      rd_vld        <= 1'b0;
      in_grid_q     <= 1'b0;
      last_q        <= 1'b0;
      num_ok_q      <= 1'b0;
    end else begin
      if (state == F_CLEAR) clr_cnt <= clr_cnt + 1'b1;

      // geometry recompute after a register write
      if (cfg_write) begin
        geo_busy <= 1'b1;
        geo_load <= 1'b1;
        geo_step <= '0;
      end else if (geo_busy) begin
        if (geo_step == 3'd4) begin
          row_base <= NW'(gr) * NW'(across);
          geo_busy <= 1'b0;
        end else if (geo_load) begin
          geo_dvd  <= sel_dvd;
          geo_rem  <= '0;
          geo_quo  <= '0;
          geo_cnt  <= '0;
          geo_load <= 1'b0;
        end else if (geo_cnt != GCW'(IW)) begin
          if (geo_cand >= {1'b0, sel_div}) begin
            geo_rem <= SW'(geo_cand - {1'b0, sel_div});
            geo_quo <= {geo_quo[IW-2:0], 1'b1};
          end else begin
            geo_rem <= geo_cand[SW-1:0];
            geo_quo <= {geo_quo[IW-2:0], 1'b0};
          end
          geo_dvd <= geo_dvd << 1;
          geo_cnt <= geo_cnt + 1'b1;
        end else begin
          case (geo_step)
            3'd0: across <= (int'(geo_quo) > MAX_ACROSS) ? CW'(MAX_ACROSS) : CW'(geo_quo);
            3'd1: down   <= geo_quo;
            3'd2: begin gc <= PW'(geo_quo); lc <= LW'(geo_rem); end
            default: begin gr <= PW'(geo_quo); lr <= LW'(geo_rem); end
          endcase
          geo_step <= geo_step + 1'b1;
          geo_load <= 1'b1;
        end
      end

      if (accept && (operation == OP_PIXEL) && frame_start) begin
        raster_col    <= '0;
        raster_row    <= '0;
        lc            <= '0;
        lr            <= '0;
        gc            <= '0;
        gr            <= '0;
        row_base      <= '0;
        enabled_count <= '0;
        acc_vld       <= '0;
      end

      if (state == F_READ) begin
        rd_vld    <= acc_vld[acc_addr];
        in_grid_q <= in_grid;
        last_q    <= last;
        num_ok_q  <= num_ok;
      end

      if ((state == F_UPDATE) && !hold) begin
        if (in_grid_q) acc_vld[acc_addr] <= !last_q;
        if (emit && !(col_wrap && row_wrap)) enabled_count <= enabled_count + 1'b1;
        if (col_wrap) begin
          raster_col <= '0;
          lc         <= '0;
          gc         <= '0;
          if (row_wrap) begin
            raster_row    <= '0;
            lr            <= '0;
            gr            <= '0;
            row_base      <= '0;
            enabled_count <= '0;
          end else begin
            raster_row <= raster_row + 1'b1;
            if (lr == LW'(sh_eff - 1'b1)) begin
              lr       <= '0;
              gr       <= gr + 1'b1;
              row_base <= row_base + NW'(across);
            end else begin
              lr <= lr + 1'b1;
            end
          end
        end else begin
          raster_col <= raster_col + 1'b1;
          if (lc == LW'(sw_eff - 1'b1)) begin
            lc <= '0;
            gc <= gc + 1'b1;
          end else begin
            lc <= lc + 1'b1;
          end
        end
      end
    end
  end

  // payload capture and memories
  always_ff @(posedge clk) begin
    if (accept) px_q <= pixel;
    if (state == F_CLEAR) begin
      mask_mem[clr_cnt] <= 1'b0;
    end else if (mask_wr) begin
      mask_mem[MW'(mask_index)] <= mask_bit;
    end
    if (state == F_READ) begin
      rd_mask <= mask_mem[MW'(num)];
      rd_ws   <= ws_mem[acc_addr];
      rd_rm   <= rm_mem[acc_addr];
      rd_cm   <= cm_mem[acc_addr];
    end
    if (acc_we) begin
      ws_mem[acc_addr] <= ws_new;
      rm_mem[acc_addr] <= rm_new;
      cm_mem[acc_addr] <= cm_new;
    end
  end

endmodule

// ----- src/stc_queue.sv -----
// ----------------------------------------------------------------------------
// stc_queue
// short job queue between the pixel front and the centroid back
// ----------------------------------------------------------------------------
module stc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  stc_pkg::job_t    din,
  input  logic             pop,
  output stc_pkg::job_t    dout,
  output stc_pkg::q_stat_t stat
);
  import stc_pkg::*;

  localparam int PTW = $clog2(QDEPTH);
  localparam int CNW = $clog2(QDEPTH + 1);

  job_t           entries [QDEPTH];
  logic [PTW-1:0] wr_ptr, rd_ptr;
  logic [CNW-1:0] count;

  assign dout       = entries[rd_ptr];
  assign stat.full  = (count == CNW'(QDEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= din;
  end

endmodule

// ----- src/stc_back.sv -----
// ----------------------------------------------------------------------------
// stc_back
// centroid division, one quotient bit per cycle, and output register
// ----------------------------------------------------------------------------
module stc_back (
  input  logic                       clk,
  input  logic                       rst,
  input  stc_pkg::job_t              job,
  input  stc_pkg::q_stat_t           q_stat,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [stc_pkg::IDXW-1:0]   aperture_index,
  output logic [stc_pkg::CTRW-1:0]   row_center,
  output logic [stc_pkg::CTRW-1:0]   col_center,
  output logic                       empty_res
);
  import stc_pkg::*;

  localparam int NB  = MOMW + QFRAC;
  localparam int BCW = $clog2(NB + 1);

  back_state_t state, state_next;

  logic [IDXW-1:0] idx_q;
  logic            emp_q;
  logic [WSW-1:0]  dvs;
  logic [NB-1:0]   dr, dc;
  logic [WSW-1:0]  rr, rc;
  logic [CTRW-1:0] qr, qc;
  logic [BCW-1:0]  cnt;
  logic [WSW:0]    cand_r, cand_c;
  logic            free;

  assign cand_r = {rr, dr[NB-1]};
  assign cand_c = {rc, dc[NB-1]};
  assign free   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    case (state)
      B_IDLE: begin
        if (!q_stat.empty) begin
          pop        = 1'b1;
          state_next = (job.ws == '0) ? B_DONE : B_DIV;
        end
      end
      B_DIV:   if (cnt == BCW'(NB - 1)) state_next = B_DONE;
      B_DONE:  if (free) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == B_DONE) && free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        idx_q <= job.idx;
        emp_q <= (job.ws == '0);
        dvs   <= job.ws;
        dr    <= {job.rm, QFRAC'(0)};
        dc    <= {job.cm, QFRAC'(0)};
        rr    <= '0;
        rc    <= '0;
        qr    <= '0;
        qc    <= '0;
        cnt   <= '0;
      end
      B_DIV: begin
        if (cand_r >= {1'b0, dvs}) begin
          rr <= WSW'(cand_r - {1'b0, dvs});
          qr <= {qr[CTRW-2:0], 1'b1};
        end else begin
          rr <= cand_r[WSW-1:0];
          qr <= {qr[CTRW-2:0], 1'b0};
        end
        if (cand_c >= {1'b0, dvs}) begin
          rc <= WSW'(cand_c - {1'b0, dvs});
          qc <= {qc[CTRW-2:0], 1'b1};
        end else begin
          rc <= cand_c[WSW-1:0];
          qc <= {qc[CTRW-2:0], 1'b0};
        end
        dr  <= dr << 1;
        dc  <= dc << 1;
        cnt <= cnt + 1'b1;
      end
      B_DONE: begin
        if (free) begin
          aperture_index <= idx_q;
          row_center     <= emp_q ? '0 : qr;
          col_center     <= emp_q ? '0 : qc;
          empty_res      <= emp_q;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- src/subaperture_threshold_centroid.sv -----
// pixel item: accept, accumulator read, then update, which waits while the job queue is full; mask write: accept only
// result: follows the last pixel of an enabled subaperture through the job queue
//   and the 38-step bit-serial centroid divider
// reset: mask store cleared entry by entry, input stalled meanwhile
// any register write recomputes the grid with the serial divider,
//   input stalled meanwhile
// ----------------------------------------------------------------------------
// subaperture_threshold_centroid
// thresholded center of gravity over a grid of subapertures
// ----------------------------------------------------------------------------
module subaperture_threshold_centroid #(
  parameter int MAX_IMAGE     = stc_pkg::MAX_IMAGE_DEF,
  parameter int MAX_SUB       = stc_pkg::MAX_SUB_DEF,
  parameter int MAX_ACROSS    = stc_pkg::MAX_ACROSS_DEF,
  parameter int MAX_APERTURES = stc_pkg::MAX_APERTURES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [stc_pkg::CFG_AW-1:0]      cfg_index,
  input  logic [stc_pkg::CFG_DW-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            operation,
  input  logic signed [stc_pkg::PIXW-1:0] pixel,
  input  logic                            frame_start,
  input  logic [stc_pkg::IDXW-1:0]        mask_index,
  input  logic                            mask_bit,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [stc_pkg::IDXW-1:0]        aperture_index,
  output logic [stc_pkg::CTRW-1:0]        row_center,
  output logic [stc_pkg::CTRW-1:0]        col_center,
  output logic                            empty_res
);
  import stc_pkg::*;

  job_t    job_in, job_out;
  q_stat_t q_stat;
  logic    job_push, job_pop;

  stc_front #(
    .MAX_IMAGE     (MAX_IMAGE),
    .MAX_SUB       (MAX_SUB),
    .MAX_ACROSS    (MAX_ACROSS),
    .MAX_APERTURES (MAX_APERTURES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .pixel       (pixel),
    .frame_start (frame_start),
    .mask_index  (mask_index),
    .mask_bit    (mask_bit),
    .job_push    (job_push),
    .job         (job_in),
    .q_stat      (q_stat)
  );

  stc_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (job_push),
    .din  (job_in),
    .pop  (job_pop),
    .dout (job_out),
    .stat (q_stat)
  );

  stc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .job            (job_out),
    .q_stat         (q_stat),
    .pop            (job_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .aperture_index (aperture_index),
    .row_center     (row_center),
    .col_center     (col_center),
    .empty_res      (empty_res)
  );

endmodule

// ----- src/stc_checker.sv -----
// ----------------------------------------------------------------------------
// stc_checker
// port-level checks of the subaperture centroid block
// ----------------------------------------------------------------------------
`include "subaperture_threshold_centroid_macros.svh"

module stc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [stc_pkg::CTRW-1:0]      row_center,
  input logic [stc_pkg::CTRW-1:0]      col_center,
  input logic                          empty_res
);

  // stalled result stays offered
  `STC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  // empty subaperture carries zero centroids
  `STC_ASSERT_IMP(a_empty_zero, out_valid && empty_res, (row_center == '0) && (col_center == '0))

  // mask clearing follows reset, no transfer in
  `STC_ASSERT_IMP(a_clear_stall, $fell(rst), in_stall)

endmodule

bind subaperture_threshold_centroid stc_checker u_stc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .row_center (row_center),
  .col_center (col_center),
  .empty_res  (empty_res)
);

// ----- sim/tb_subaperture_threshold_centroid.sv -----
// ----------------------------------------------------------------------------
// subaperture centroid testbench
// drives pixel frames and mask writes over several grid settings, with random
// sender bursts, receiver stalls and one long receiver hold-off; a scoreboard
// predicts each centroid result and checks the block's output in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import stc_pkg::*;

class centroid_scoreboard;
  bit [TW-1:0]   thr;
  bit [DIMW-1:0] img_w, img_h;
  bit [SUBW-1:0] sub_w, sub_h;
  bit            mask_store [1024];
  bit [WSW-1:0]  wsum [64];
  bit [MOMW-1:0] rmom [64];
  bit [MOMW-1:0] cmom [64];
  int unsigned   cur_row, cur_col, enabled;
  bit [IDXW+2*CTRW:0] pending [$];
  int errors, results, empties;

  function new();
    thr = THRESHOLD_RST; img_w = IMAGE_WIDTH_RST; img_h = IMAGE_HEIGHT_RST;
    sub_w = SUB_WIDTH_RST; sub_h = SUB_HEIGHT_RST;
    foreach (mask_store[i]) mask_store[i] = 0;
    clear_sums();
    cur_row = 0; cur_col = 0; enabled = 0;
  endfunction

  function void clear_sums();
    foreach (wsum[i]) begin
      wsum[i] = 0; rmom[i] = 0; cmom[i] = 0;
    end
  endfunction

  function void set_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
    case (idx)
      REG_THRESHOLD: if (val >= 1 && val < THRESH_LIMIT) thr = val;
      REG_IMAGE_WIDTH: img_w = val[DIMW-1:0];
      REG_IMAGE_HEIGHT: img_h = val[DIMW-1:0];
      REG_SUB_WIDTH: sub_w = val[SUBW-1:0];
      REG_SUB_HEIGHT: sub_h = val[SUBW-1:0];
      default: ;
    endcase
  endfunction

  function int unsigned span(int unsigned v);
    if (v == 0) return 1;
    return v > 512 ? 512 : v;
  endfunction

  function void note_input(logic op, logic signed [PIXW-1:0] px, logic fs,
                           logic [IDXW-1:0] midx, logic mbit);
    int unsigned w, h, sw, sh, across, down, gc, gr, lc, lr, num;
    longint unsigned v, s;
    bit [CTRW-1:0] rc, cc;
    if (op == OP_MASK) begin
      mask_store[midx] = mbit;
      return;
    end
    w = span(img_w); h = span(img_h);
    if (fs) begin
      cur_row = 0; cur_col = 0; enabled = 0; clear_sums();
    end
    if (sub_w != 0 && sub_h != 0) begin
      sw = sub_w > 32 ? 32 : sub_w;
      sh = sub_h > 32 ? 32 : sub_h;
      across = w / sw; down = h / sh;
      if (across > 64) across = 64;
      gc = cur_col / sw; gr = cur_row / sh;
      if (gc < across && gr < down) begin
        lc = cur_col % sw; lr = cur_row % sh;
        if (int'(px) > int'(thr)) begin
          v = longint'(px);
          wsum[gc] = WSW'(wsum[gc] + v);
          rmom[gc] = MOMW'(rmom[gc] + v * lr);
          cmom[gc] = MOMW'(cmom[gc] + v * lc);
        end
        if (lc == sw - 1 && lr == sh - 1) begin
          num = gr * across + gc;
          if (num < 1024 && mask_store[num]) begin
            s = wsum[gc];
            if (s == 0) begin
              pending.push_back({enabled[IDXW-1:0], 13'd0, 13'd0, 1'b1});
            end else begin
              rc = CTRW'((longint'(rmom[gc]) << 8) / s);
              cc = CTRW'((longint'(cmom[gc]) << 8) / s);
              pending.push_back({enabled[IDXW-1:0], rc, cc, 1'b0});
            end
            enabled = (enabled + 1) % 1024;
          end
          wsum[gc] = 0; rmom[gc] = 0; cmom[gc] = 0;
        end
      end
    end
    cur_col++;
    if (cur_col >= w) begin
      cur_col = 0; cur_row++;
      if (cur_row >= h) begin
        cur_row = 0; enabled = 0;
      end
    end
  endfunction

  function void check_result(logic [IDXW-1:0] idx, logic [CTRW-1:0] rc,
                             logic [CTRW-1:0] cc, logic emp);
    bit [IDXW+2*CTRW:0] e;
    results++;
    if (emp) empties++;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result idx %0d row %0d col %0d empty %0d",
               $time, idx, rc, cc, emp);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (e[2*CTRW+IDXW:2*CTRW+1] !== idx) begin
      $display("%0t: aperture_index expected %0d actual %0d", $time,
               e[2*CTRW+IDXW:2*CTRW+1], idx);
      errors++;
    end
    if (e[2*CTRW:CTRW+1] !== rc) begin
      $display("%0t: row_center expected %0d actual %0d", $time, e[2*CTRW:CTRW+1], rc);
      errors++;
    end
    if (e[CTRW:1] !== cc) begin
      $display("%0t: col_center expected %0d actual %0d", $time, e[CTRW:1], cc);
      errors++;
    end
    if (e[0] !== emp) begin
      $display("%0t: empty_res expected %0d actual %0d", $time, e[0], emp);
      errors++;
    end
  endfunction
endclass

module tb_subaperture_threshold_centroid;
  localparam int STALL_LIMIT = 20000;

  logic clk = 0, rst = 1;
  logic cfg_write = 0;
  logic [CFG_AW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;
  logic in_valid = 0, in_stall;
  logic operation = 0;
  logic signed [PIXW-1:0] pixel = '0;
  logic frame_start = 0;
  logic [IDXW-1:0] mask_index = '0;
  logic mask_bit = 0;
  logic out_valid, out_stall = 0;
  logic [IDXW-1:0] aperture_index;
  logic [CTRW-1:0] row_center, col_center;
  logic empty_res;

  centroid_scoreboard sb = new();
  int items_sent = 0, idle_cycles = 0, burst_left = 0;
  bit hold_off = 0, done = 0;

  always #10 clk = ~clk;

  subaperture_threshold_centroid DUT (.*);

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        sb.note_input(operation, pixel, frame_start, mask_index, mask_bit);
      if (out_valid && !out_stall)
        sb.check_result(aperture_index, row_center, col_center, empty_res);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog timeout", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1;
        repeat (3000) @(negedge clk);
        hold_off = 0;
        out_stall <= 0;
      end else begin
        n = $urandom_range(0, 9);
        out_stall <= (n < 3);
      end
    end
  end

  task automatic send(logic op, logic signed [PIXW-1:0] px, logic fs,
                      logic [IDXW-1:0] midx, logic mb);
    if (burst_left == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1; operation <= op; pixel <= px; frame_start <= fs;
    mask_index <= midx; mask_bit <= mb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(negedge clk);
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
    cfg_write <= 1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_write <= 0;
    sb.set_reg(idx, val);
    while (in_stall) @(negedge clk);
  endtask

  task automatic set_grid(int thr, int w, int h, int sw, int sh);
    write_reg(REG_THRESHOLD, CFG_DW'(thr));
    write_reg(REG_IMAGE_WIDTH, CFG_DW'(w));
    write_reg(REG_IMAGE_HEIGHT, CFG_DW'(h));
    write_reg(REG_SUB_WIDTH, CFG_DW'(sw));
    write_reg(REG_SUB_HEIGHT, CFG_DW'(sh));
  endtask

  task automatic random_pixel(int thr, bit fs);
    logic signed [PIXW-1:0] px;
    case ($urandom_range(0, 5))
      0: px = PIXW'($urandom);
      1: px = PIXW'(thr);
      2: px = 16'sh7fff;
      3: px = PIXW'($urandom_range(0, 3));
      default: px = PIXW'(thr + $urandom_range(1, 3000));
    endcase
    send(OP_PIXEL, px, fs, IDXW'($urandom), 1'($urandom));
  endtask

  task automatic run_frame(int thr, int npix);
    for (int i = 0; i < npix; i++) begin
      if ($urandom_range(0, 60) == 0)
        send(OP_MASK, PIXW'($urandom), 1'($urandom), IDXW'($urandom), 1'($urandom));
      random_pixel(thr, i == 0);
    end
  endtask

  task automatic enable_masks(int count, bit all_on);
    for (int i = 0; i < count; i++)
      send(OP_MASK, PIXW'($urandom), 1'($urandom), IDXW'(i),
           all_on ? 1'b1 : 1'($urandom));
  endtask

  initial begin
    int thr, w, h, sw, sh;
    repeat (6) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    while (in_stall) @(negedge clk);

    // directed: 2x2 subapertures on a 4x4 image, extremes and empty case
    set_grid(8000, 4, 4, 2, 2);
    set_grid(0, 4, 4, 2, 2);
    set_grid(7999, 4, 4, 2, 2);
    enable_masks(4, 1);
    send(OP_MASK, 0, 0, 1023, 1);
    send(OP_MASK, 0, 0, 2, 0);
    send(OP_PIXEL, 16'sh7fff, 1, 0, 0);
    send(OP_PIXEL, -16'sh8000, 0, 0, 0);
    send(OP_PIXEL, 16'sh7fff, 0, 0, 0);
    send(OP_PIXEL, 7999, 0, 0, 0);
    send(OP_PIXEL, 8000, 0, 0, 0);
    send(OP_PIXEL, 16'sh1fff, 0, 0, 0);
    send(OP_PIXEL, 0, 0, 0, 0);
    send(OP_PIXEL, 16'sh7fff, 0, 0, 0);
    for (int i = 0; i < 8; i++) send(OP_PIXEL, -1, 0, 0, 0);
    send(OP_PIXEL, 16'sh5555, 0, 0, 0);
    drain();
    write_reg(REG_THRESHOLD, 1);
    write_reg(REG_SUB_WIDTH, 0);
    for (int i = 0; i < 4; i++) send(OP_PIXEL, 16'sh2aaa, i == 0, 0, 0);
    drain();

    // long receiver hold-off while the sender keeps offering pixels
    set_grid(1, 4, 4, 1, 1);
    enable_masks(16, 1);
    hold_off = 1;
    for (int i = 0; i < 48; i++) random_pixel(1, i == 0);
    drain();

    // random frames over many grid settings, mostly small sizes
    for (int ph = 0; items_sent < 880 || ph < 6; ph++) begin
      thr = (ph % 5 == 0) ? 1 : $urandom_range(1, 7999);
      case (ph % 7)
        0: begin w = 1023; h = 1023; sw = 63; sh = 63; end
        1: begin w = 0; h = 0; sw = 1; sh = 1; end
        2: begin w = 130; h = 2; sw = 2; sh = 2; end
        3: begin w = $urandom_range(1, 10); h = $urandom_range(1, 10);
                 sw = 32; sh = 3; end
        default: begin
          w = $urandom_range(2, 12); h = $urandom_range(2, 12);
          sw = $urandom_range(1, 4); sh = $urandom_range(1, 4);
        end
      endcase
      set_grid(thr, w, h, sw, sh);
      enable_masks(ph % 7 == 2 ? 70 : 40, ph % 3 == 0);
      case (ph % 7)
        0: run_frame(thr, 60);
        2: run_frame(thr, 260 + $urandom_range(0, 40));
        default: run_frame(thr, $urandom_range(1, 2) * w * h + $urandom_range(0, 5));
      endcase
      drain();
    end

    $display("%0d items sent, %0d centroid results checked (%0d empty)",
             items_sent, sb.results, sb.empties);
    $display("grids covered: extreme thresholds and sizes, zero sizes, wide rows");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
